// ----- rtl/bsc_pkg.sv -----
// shared types and constants of the barometric compensation block
package bsc_pkg;

   localparam int RAW_W       = 20;
   localparam int TEMP_W      = 16;
   localparam int PRESS_W     = 25;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int DIV_STEPS   = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_CAL      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_CAL_LO  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_CAL_HI  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_CURV    = 2'd3;

   localparam logic signed [25:0] FINE_OFFSET = 26'sd128000;
   localparam logic [20:0]        PRESS_BASE  = 21'd1048576;
   localparam logic [11:0]        PRESS_SCALE = 12'd3125;
   localparam logic signed [27:0] TEMP_ROUND  = 28'sd128;
   localparam logic signed [27:0] TEMP_SCALE  = 28'sd5;
   localparam logic [47:0]        OFFSET_47   = 48'h8000_0000_0000;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } coeff_type;

   typedef struct packed {
      logic [TEMP_W-1:0] temp;
      logic              dz;
   } side_type;

   typedef struct packed {
      side_type    side;
      logic [63:0] num;
      logic [30:0] den;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

// ----- rtl/bsc_front.sv -----
// front pipeline: temperature compensation and divider operands
module bsc_front import bsc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  coeff_type        coeff,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [RAW_W-1:0] req_raw_temperature,
   input  logic [RAW_W-1:0] req_raw_pressure,
   input  queue_status_type q_status,
   output logic             push,
   output entry_type        push_entry
);

   localparam int STAGES = 9;
   localparam logic signed [19:0] T_MIN = -20'sd32768;
   localparam logic signed [19:0] T_MAX = 20'sd32767;

   logic en;
   logic [STAGES-1:0] valid_ff, valid_in;

   logic signed [15:0] t2_s, t3_s, p2_s, p5_s, p3_s, p6_s;
   assign t2_s = $signed(coeff.t2);
   assign t3_s = $signed(coeff.t3);
   assign p2_s = $signed(coeff.p2);
   assign p3_s = $signed(coeff.p3);
   assign p5_s = $signed(coeff.p5);
   assign p6_s = $signed(coeff.p6);

   assign en        = !(valid_ff[STAGES-1] && q_status.full);
   assign req_ready = en;
   assign push      = valid_ff[STAGES-1] && !q_status.full;
   assign valid_in  = {valid_ff[STAGES-2:0], req_valid};

   // stage 1
   logic signed [18:0] tdiff;
   logic signed [17:0] td;
   logic signed [35:0] tdsq_full;
   logic signed [34:0] ta_ff, ta_in;
   logic [31:0] tdsq_ff, tdsq_in;
   logic [20:0] pb_ff [1:6];
   logic [20:0] pb_in;
   assign tdiff = $signed({2'b00, req_raw_temperature[19:3]})
                - $signed({2'b00, coeff.t1, 1'b0});
   assign ta_in = tdiff * t2_s;
   assign td = $signed({2'b00, req_raw_temperature[19:4]}) - $signed({2'b00, coeff.t1});
   assign tdsq_full = td * td;
   assign tdsq_in = tdsq_full[31:0];
   assign pb_in = PRESS_BASE - {1'b0, req_raw_pressure};

   // stage 2
   logic signed [23:0] ta_sh_ff, ta_sh_in;
   logic signed [36:0] tb_ff, tb_in;
   assign ta_sh_in = ta_ff[34:11];
   assign tb_in = $signed({1'b0, tdsq_ff[31:12]}) * t3_s;

   // stage 3
   logic signed [24:0] fine;
   logic signed [27:0] tscaled;
   logic signed [19:0] tshift;
   logic [15:0] temp_in;
   logic [15:0] temp_ff [3:8];
   logic signed [25:0] v1_ff, v1_in;
   assign fine = {ta_sh_ff[23], ta_sh_ff} + {{2{tb_ff[36]}}, tb_ff[36:14]};
   assign tscaled = $signed({{3{fine[24]}}, fine}) * TEMP_SCALE + TEMP_ROUND;
   assign tshift = tscaled[27:8];
   always_comb begin
      if (tshift < T_MIN) begin
         temp_in = 16'h8000;
      end else if (tshift > T_MAX) begin
         temp_in = 16'h7fff;
      end else begin
         temp_in = tshift[15:0];
      end
   end
   assign v1_in = {fine[24], fine} - FINE_OFFSET;

   // stage 4
   logic signed [51:0] vsq_ff, vsq_in;
   logic signed [41:0] v1p5_ff, v1p5_in, v1p2_ff, v1p2_in;
   logic signed [41:0] v1p5_d_ff, v1p2_d_ff;
   assign vsq_in  = v1_ff * v1_ff;
   assign v1p5_in = v1_ff * p5_s;
   assign v1p2_in = v1_ff * p2_s;

   // stage 5
   logic signed [63:0] x6_ff, x6_in, x3_ff, x3_in;
   assign x6_in = vsq_ff * p6_s;
   assign x3_in = vsq_ff * p3_s;

   // stage 6
   logic [63:0] v2_ff, v2_in, s_ff, s_in;
   assign v2_in = x6_ff + ({{22{v1p5_d_ff[41]}}, v1p5_d_ff} << 17)
                + ({{48{coeff.p4[15]}}, coeff.p4} << 35);
   assign s_in = {{8{x3_ff[63]}}, x3_ff[63:8]} + ({{22{v1p2_d_ff[41]}}, v1p2_d_ff} << 12)
               + {16'b0, OFFSET_47};

   // stage 7
   logic [47:0] pl_ff, pl_in;
   logic [31:0] ph_ff, ph_in;
   logic [63:0] w_ff, w_in;
   assign pl_in = s_ff[31:0] * coeff.p1;
   assign ph_in = s_ff[63:32] * {16'b0, coeff.p1};
   assign w_in  = ({43'b0, pb_ff[6]} << 31) - v2_ff;

   // stage 8
   logic [63:0] vsum;
   logic [30:0] den_ff, den_in;
   logic [43:0] nl_ff, nl_in;
   logic [31:0] nh_ff, nh_in;
   assign vsum   = {16'b0, pl_ff} + {ph_ff, 32'b0};
   assign den_in = vsum[63:33];
   assign nl_in  = w_ff[31:0] * PRESS_SCALE;
   assign nh_in  = w_ff[63:32] * {20'b0, PRESS_SCALE};

   // stage 9
   entry_type entry_ff, entry_in;
   assign entry_in.num       = {20'b0, nl_ff} + {nh_ff, 32'b0};
   assign entry_in.den       = den_ff;
   assign entry_in.side.dz   = (den_ff == 31'd0);
   assign entry_in.side.temp = temp_ff[8];
   assign push_entry = entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ta_ff     <= ta_in;
         tdsq_ff   <= tdsq_in;
         pb_ff[1]  <= pb_in;
         for (int i = 2; i <= 6; i++) pb_ff[i] <= pb_ff[i-1];
         ta_sh_ff  <= ta_sh_in;
         tb_ff     <= tb_in;
         temp_ff[3] <= temp_in;
         for (int i = 4; i <= 8; i++) temp_ff[i] <= temp_ff[i-1];
         v1_ff     <= v1_in;
         vsq_ff    <= vsq_in;
         v1p5_ff   <= v1p5_in;
         v1p2_ff   <= v1p2_in;
         v1p5_d_ff <= v1p5_ff;
         v1p2_d_ff <= v1p2_ff;
         x6_ff     <= x6_in;
         x3_ff     <= x3_in;
         v2_ff     <= v2_in;
         s_ff      <= s_in;
         pl_ff     <= pl_in;
         ph_ff     <= ph_in;
         w_ff      <= w_in;
         den_ff    <= den_in;
         nl_ff     <= nl_in;
         nh_ff     <= nh_in;
         entry_ff  <= entry_in;
      end
   end

endmodule

// ----- rtl/bsc_queue.sv -----
// short queue between the front and back pipelines
module bsc_queue import bsc_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head_entry,
   output queue_status_type q_status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign wr_ptr_in = !push ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head_entry         = slot_ff[rd_ptr_ff];
   assign q_status.not_empty = (count_ff != '0);
   assign q_status.full      = (count_ff == CNT_W'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/bsc_divider.sv -----
// pipelined signed divider, one quotient bit per stage, truncating toward zero
module bsc_divider import bsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [63:0] num,
   input  logic [30:0] den,
   input  side_type    side_in,
   output logic        out_valid,
   output logic [63:0] quot,
   output side_type    side_out
);

   logic [30:0] rem_ff [0:DIV_STEPS];
   logic [30:0] rem_in [0:DIV_STEPS];
   logic [63:0] nq_ff  [0:DIV_STEPS];
   logic [63:0] nq_in  [0:DIV_STEPS];
   logic [30:0] dm_ff  [0:DIV_STEPS];
   logic [30:0] dm_in  [0:DIV_STEPS];
   logic        neg_ff [0:DIV_STEPS];
   logic        neg_in [0:DIV_STEPS];
   side_type    side_ff [0:DIV_STEPS];
   side_type    side_in_a [0:DIV_STEPS];
   logic [DIV_STEPS:0] valid_ff, valid_in;
   logic [63:0] quot_ff, quot_in;
   side_type    side_o_ff;
   logic        out_valid_ff;

   // magnitudes at entry; a zero divisor is replaced so the stages stay defined
   assign rem_in[0]    = '0;
   assign nq_in[0]     = num[63] ? (64'd0 - num) : num;
   assign dm_in[0]     = (den == 31'd0) ? 31'd1 : (den[30] ? (31'd0 - den) : den);
   assign neg_in[0]    = num[63] ^ den[30];
   assign side_in_a[0] = side_in;
   assign valid_in     = {valid_ff[DIV_STEPS-1:0], in_valid};

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [31:0] trial, diff;
      logic        ge;
      assign trial = {rem_ff[k], nq_ff[k][63]};
      assign diff  = trial - {1'b0, dm_ff[k]};
      assign ge    = (trial >= {1'b0, dm_ff[k]});
      assign rem_in[k+1]    = ge ? diff[30:0] : trial[30:0];
      assign nq_in[k+1]     = {nq_ff[k][62:0], ge};
      assign dm_in[k+1]     = dm_ff[k];
      assign neg_in[k+1]    = neg_ff[k];
      assign side_in_a[k+1] = side_ff[k];
   end

   assign quot_in = neg_ff[DIV_STEPS] ? (64'd0 - nq_ff[DIV_STEPS]) : nq_ff[DIV_STEPS];

   assign out_valid = out_valid_ff;
   assign quot      = quot_ff;
   assign side_out  = side_o_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff    <= rem_in;
         nq_ff     <= nq_in;
         dm_ff     <= dm_in;
         neg_ff    <= neg_in;
         side_ff   <= side_in_a;
         quot_ff   <= quot_in;
         side_o_ff <= side_ff[DIV_STEPS];
      end
   end

endmodule

// ----- rtl/bsc_back.sv -----
// back pipeline: division, curvature terms, offset and output register
module bsc_back import bsc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  coeff_type          coeff,
   input  entry_type          head_entry,
   input  queue_status_type   q_status,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [TEMP_W-1:0] rsp_temperature_centi,
   output logic [PRESS_W-1:0] rsp_pressure_q24_8,
   output logic               rsp_divide_by_zero
);

   localparam int POST = 5;

   logic en;
   logic div_valid;
   logic [63:0] q;
   side_type div_side;
   logic [POST-1:0] valid_ff, valid_in;
   logic rsp_valid_ff;

   logic signed [15:0] p8_s, p9_s;
   logic [31:0] p8x, p9x;
   assign p8_s = $signed(coeff.p8);
   assign p9_s = $signed(coeff.p9);
   assign p8x  = {{16{coeff.p8[15]}}, coeff.p8};
   assign p9x  = {{16{coeff.p9[15]}}, coeff.p9};

   assign en  = !rsp_valid_ff || rsp_ready;
   assign pop = en && q_status.not_empty;

   bsc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pop),
      .num       (head_entry.num),
      .den       (head_entry.den),
      .side_in   (head_entry.side),
      .out_valid (div_valid),
      .quot      (q),
      .side_out  (div_side)
   );

   assign valid_in = {valid_ff[POST-2:0], div_valid};

   // stage a: x = p >>> 13, partial products of p9*x and p8*p
   logic [63:0] x_in, x_ff, x_d_ff;
   logic signed [63:0] ml_ff, ml_in, bl_ff, bl_in;
   logic [31:0] mh_ff, mh_in, bh_ff, bh_in;
   logic [63:0] p_ff [0:3];
   side_type side_ff [0:4];
   assign x_in  = {{13{q[63]}}, q[63:13]};
   assign ml_in = $signed({1'b0, x_in[31:0]}) * p9_s;
   assign mh_in = x_in[63:32] * p9x;
   assign bl_in = $signed({1'b0, q[31:0]}) * p8_s;
   assign bh_in = q[63:32] * p8x;

   // stage b: assemble the two products
   logic [63:0] m1_ff, m1_in, bb, b_in;
   logic [63:0] b_ff [0:2];
   assign m1_in = ml_ff + {mh_ff, 32'b0};
   assign bb    = bl_ff + {bh_ff, 32'b0};
   assign b_in  = {{19{bb[63]}}, bb[63:19]};

   // stage c: (p9*x)*x modulo 2^64 from three partial products
   logic [63:0] ll_ff, ll_in;
   logic [31:0] lh_ff, lh_in, hl_ff, hl_in;
   assign ll_in = m1_ff[31:0] * x_d_ff[31:0];
   assign lh_in = m1_ff[31:0] * x_d_ff[63:32];
   assign hl_in = m1_ff[63:32] * x_d_ff[31:0];

   // stage d
   logic [63:0] prod, a_ff, a_in;
   assign prod = ll_ff + {lh_ff + hl_ff, 32'b0};
   assign a_in = {{25{prod[63]}}, prod[63:25]};

   // stage e
   logic [63:0] sum_ff, sum_in;
   assign sum_in = p_ff[3] + a_ff + b_ff[2];

   // output register
   logic [63:0] fin;
   logic [PRESS_W-1:0] press_in, press_ff;
   logic [TEMP_W-1:0] temp_ff;
   logic dz_ff;
   assign fin = {{8{sum_ff[63]}}, sum_ff[63:8]} + ({{48{coeff.p7[15]}}, coeff.p7} << 4);
   always_comb begin
      if (side_ff[4].dz || fin[63]) begin
         press_in = '0;
      end else if (|fin[62:PRESS_W]) begin
         press_in = '1;
      end else begin
         press_in = fin[PRESS_W-1:0];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = $signed(temp_ff);
   assign rsp_pressure_q24_8    = press_ff;
   assign rsp_divide_by_zero    = dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[POST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff       <= x_in;
         x_d_ff     <= x_ff;
         ml_ff      <= ml_in;
         mh_ff      <= mh_in;
         bl_ff      <= bl_in;
         bh_ff      <= bh_in;
         p_ff[0]    <= q;
         for (int i = 1; i <= 3; i++) p_ff[i] <= p_ff[i-1];
         side_ff[0] <= div_side;
         for (int i = 1; i <= 4; i++) side_ff[i] <= side_ff[i-1];
         m1_ff      <= m1_in;
         b_ff[0]    <= b_in;
         b_ff[1]    <= b_ff[0];
         b_ff[2]    <= b_ff[1];
         ll_ff      <= ll_in;
         lh_ff      <= lh_in;
         hl_ff      <= hl_in;
         a_ff       <= a_in;
         sum_ff     <= sum_in;
         press_ff   <= press_in;
         temp_ff    <= side_ff[4].temp;
         dz_ff      <= side_ff[4].dz;
      end
   end

endmodule

// ----- rtl/baro_sensor_compensation.sv -----
// top level of the barometric temperature and pressure compensation block
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    raw_temperature, raw_pressure
//   rsp      out        rsp_valid/rsp_ready    temperature_centi, pressure_q24_8,
//                                              divide_by_zero
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// one word accepted per cycle while the front is not stalled; the depth
// from accept to rsp_valid is set by the 64-stage divider and the multiply stages.
// reset clears the calibration registers and all stage valids.
// the front stalls only when the queue is full, the back only when the output
// register holds a word that is not taken; csr_ready is always high.
module baro_sensor_compensation import bsc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [RAW_W-1:0]       req_raw_temperature,
   input  logic [RAW_W-1:0]       req_raw_pressure,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [TEMP_W-1:0] rsp_temperature_centi,
   output logic [PRESS_W-1:0]     rsp_pressure_q24_8,
   output logic                   rsp_divide_by_zero,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [47:0] tcal_ff;
   logic [63:0] pcal_lo_ff, pcal_hi_ff;
   logic [15:0] curv_ff;
   coeff_type coeff;
   queue_status_type q_status;
   entry_type push_entry, head_entry;
   logic push, pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff    <= '0;
         pcal_lo_ff <= '0;
         pcal_hi_ff <= '0;
         curv_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TEMP_CAL: begin
               tcal_ff <= csr_data[47:0];
            end
            CSR_PRESS_CAL_LO: begin
               pcal_lo_ff <= csr_data;
            end
            CSR_PRESS_CAL_HI: begin
               pcal_hi_ff <= csr_data;
            end
            CSR_PRESS_CURV: begin
               curv_ff <= csr_data[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign coeff.t1 = tcal_ff[15:0];
   assign coeff.t2 = tcal_ff[31:16];
   assign coeff.t3 = tcal_ff[47:32];
   assign coeff.p1 = pcal_lo_ff[15:0];
   assign coeff.p2 = pcal_lo_ff[31:16];
   assign coeff.p3 = pcal_lo_ff[47:32];
   assign coeff.p4 = pcal_lo_ff[63:48];
   assign coeff.p5 = pcal_hi_ff[15:0];
   assign coeff.p6 = pcal_hi_ff[31:16];
   assign coeff.p7 = pcal_hi_ff[47:32];
   assign coeff.p8 = pcal_hi_ff[63:48];
   assign coeff.p9 = curv_ff;

   bsc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .coeff               (coeff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_raw_temperature (req_raw_temperature),
      .req_raw_pressure    (req_raw_pressure),
      .q_status            (q_status),
      .push                (push),
      .push_entry          (push_entry)
   );

   bsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   bsc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .coeff                 (coeff),
      .head_entry            (head_entry),
      .q_status              (q_status),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_q24_8    (rsp_pressure_q24_8),
      .rsp_divide_by_zero    (rsp_divide_by_zero)
   );

endmodule
